// ----- src/flat_field_pixel_correct_core_assert.svh -----
// assertion macros shared by the flat field correction modules
`ifndef FLAT_FIELD_PIXEL_CORRECT_CORE_ASSERT_SVH
`define FLAT_FIELD_PIXEL_CORRECT_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define FFPC_ASSERT_HOLDS(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("ffpc assertion failed");

// condition implies consequence in the next cycle
`define FFPC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("ffpc assertion failed");

`endif

// ----- src/ffpc_pkg.sv -----
// shared constants and types of the flat field correction block
package ffpc_pkg;

	// gain is Q4.G
	localparam int GAIN_INT_BITS = 4;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_OFFSET_SELECT    = 2'd0;
	localparam cfg_idx_t REG_CONST_OFFSET     = 2'd1;
	localparam cfg_idx_t REG_ROUND_TO_INTEGER = 2'd2;

	// per item classification flags
	typedef struct packed {
		logic num_pos;
		logic zero_gain;
		logic round_int;
	} ffpc_flags_t;

endpackage

// ----- src/ffpc_if.sv -----
// valid/ready channels for input voxels and corrected results
interface ffpc_in_if #(
	parameter int PIX_W  = 16,
	parameter int BG_W   = 20,
	parameter int GAIN_W = 16
);
	logic              valid;
	logic              ready;
	logic [PIX_W-1:0]  raw_pixel;
	logic [BG_W-1:0]   background;
	logic [GAIN_W-1:0] flat_gain;

	modport source (output valid, output raw_pixel, output background, output flat_gain,
		input ready);
	modport sink (input valid, input raw_pixel, input background, input flat_gain,
		output ready);
endinterface

interface ffpc_out_if #(
	parameter int OUT_W = 20
);
	logic             valid;
	logic             ready;
	logic [OUT_W-1:0] corrected;
	logic             saturated;
	logic             zero_gain_error;

	modport source (output valid, output corrected, output saturated,
		output zero_gain_error, input ready);
	modport sink (input valid, input corrected, input saturated,
		input zero_gain_error, output ready);
endinterface

// ----- src/ffpc_front.sv -----
// front end: accepts voxels, forms the numerator and classifies each item
module ffpc_front #(
	parameter int PIXEL_BITS     = 16,
	parameter int FRAC_BITS      = 4,
	parameter int GAIN_FRAC_BITS = 12
) (
	ffpc_in_if.sink                                      in_ch,
	input  logic                                         offset_select,
	input  logic [PIXEL_BITS+FRAC_BITS-1:0]              const_offset,
	input  logic                                         round_int,
	input  logic                                         push_ready,
	output logic                                         push_valid,
	output logic [PIXEL_BITS+FRAC_BITS-1:0]              num,
	output logic [ffpc_pkg::GAIN_INT_BITS+GAIN_FRAC_BITS-1:0] gain,
	output logic [PIXEL_BITS+FRAC_BITS-1:0]              addend,
	output ffpc_pkg::ffpc_flags_t                        flags
);
	localparam int W = PIXEL_BITS + FRAC_BITS;

	logic [W-1:0] scaled;
	logic [W-1:0] diff;
	logic         pos;

	// handshake passes straight to the queue
	assign push_valid  = in_ch.valid;
	assign in_ch.ready = push_ready;

	// numerator raw*2^F - background, zero when not positive
	assign scaled = W'(in_ch.raw_pixel) << FRAC_BITS;
	assign pos    = scaled > in_ch.background;
	assign diff   = scaled - in_ch.background;
	assign num    = pos ? diff : '0;
	assign gain   = in_ch.flat_gain;

	// offset chosen now so the back end needs no configuration
	assign addend = offset_select ? const_offset : in_ch.background;

	// classification flags
	always_comb begin
		flags.num_pos   = pos;
		flags.zero_gain = (in_ch.flat_gain == '0);
		flags.round_int = round_int;
	end
endmodule

// ----- src/ffpc_fifo.sv -----
// short queue between front end and back end
`include "flat_field_pixel_correct_core_assert.svh"

module ffpc_fifo #(
	parameter int WIDTH = 59,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = store_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// fill count stays in range and moves with the handshakes
	`FFPC_ASSERT_HOLDS(a_count_range, clk, arst_n, 1'b1, count_q <= CW'(DEPTH))
	`FFPC_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)
	`FFPC_ASSERT_NEXT(a_count_down, clk, arst_n, pop && !push, count_q == $past(count_q) - 1'b1)
endmodule

// ----- src/ffpc_back.sv -----
// back end: pipelined restoring divider, offset add, rounding and saturation
`include "flat_field_pixel_correct_core_assert.svh"

module ffpc_back #(
	parameter int PIXEL_BITS     = 16,
	parameter int FRAC_BITS      = 4,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              pop_valid,
	output logic                                              pop_ready,
	input  logic [PIXEL_BITS+FRAC_BITS-1:0]                   num,
	input  logic [ffpc_pkg::GAIN_INT_BITS+GAIN_FRAC_BITS-1:0] gain,
	input  logic [PIXEL_BITS+FRAC_BITS-1:0]                   addend,
	input  ffpc_pkg::ffpc_flags_t                             flags,
	ffpc_out_if.source                                        out_ch
);
	localparam int W  = PIXEL_BITS + FRAC_BITS;
	localparam int GW = ffpc_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS;
	localparam int QW = W + GAIN_FRAC_BITS;
	localparam int RW = GW + 1;
	localparam int SW = QW + 2;
	localparam logic [SW-1:0] HALF    = (SW'(1) << FRAC_BITS) >> 1;
	localparam logic [SW-1:0] MAX_INT = (SW'(1) << PIXEL_BITS) - 1'b1;
	localparam logic [SW-1:0] MAX_Q   = (SW'(1) << W) - 1'b1;

	// divider stages: dividend shifts out the top, quotient bits enter the bottom
	logic [QW-1:0]         div_valid_s;
	logic [QW-1:0]         div_dq_s    [QW];
	logic [GW-1:0]         div_rem_s   [QW];
	logic [GW-1:0]         div_gain_s  [QW];
	logic [W-1:0]          div_add_s   [QW];
	ffpc_pkg::ffpc_flags_t div_flags_s [QW];

	// offset add stage
	logic                  fin_valid_s1;
	logic [QW:0]           fin_sum_s1;
	ffpc_pkg::ffpc_flags_t fin_flags_s1;

	// output register
	logic                  out_valid_q;
	logic [W-1:0]          out_corr_q;
	logic                  out_sat_q;
	logic                  out_zero_q;
	logic                  out_round_q;

	logic                  advance;
	logic [QW-1:0]         quot;
	logic [SW-1:0]         rounded;
	logic [SW-1:0]         maxv;
	logic                  sat;

	// whole pipe moves when the output register can take an item
	assign advance   = !out_valid_q || out_ch.ready;
	assign pop_ready = advance;

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic                  v_in;
		logic [QW-1:0]         dq_in;
		logic [GW-1:0]         rem_in;
		logic [GW-1:0]         gain_in;
		logic [W-1:0]          add_in;
		ffpc_pkg::ffpc_flags_t flags_in;
		logic [RW-1:0]         rem_sh;
		logic                  ge;
		logic [RW-1:0]         rem_diff;

		// stage input from the queue or from the previous stage
		if (k == 0) begin : g_head
			assign v_in     = pop_valid;
			assign dq_in    = QW'(num) << GAIN_FRAC_BITS;
			assign rem_in   = '0;
			assign gain_in  = gain;
			assign add_in   = addend;
			assign flags_in = flags;
		end else begin : g_body
			assign v_in     = div_valid_s[k-1];
			assign dq_in    = div_dq_s[k-1];
			assign rem_in   = div_rem_s[k-1];
			assign gain_in  = div_gain_s[k-1];
			assign add_in   = div_add_s[k-1];
			assign flags_in = div_flags_s[k-1];
		end

		// one trial subtraction
		assign rem_sh   = {rem_in, dq_in[QW-1]};
		assign ge       = rem_sh >= {1'b0, gain_in};
		assign rem_diff = rem_sh - {1'b0, gain_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s[k] <= 1'b0;
			end else if (advance) begin
				div_valid_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				div_dq_s[k]    <= {dq_in[QW-2:0], ge};
				div_rem_s[k]   <= ge ? rem_diff[GW-1:0] : rem_sh[GW-1:0];
				div_gain_s[k]  <= gain_in;
				div_add_s[k]   <= add_in;
				div_flags_s[k] <= flags_in;
			end
		end
	end

	// quotient is void for a zero gain
	assign quot = div_flags_s[QW-1].zero_gain ? '0 : div_dq_s[QW-1];

	// add the offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s1 <= 1'b0;
		end else if (advance) begin
			fin_valid_s1 <= div_valid_s[QW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fin_sum_s1   <= {1'b0, quot} + (QW+1)'(div_add_s[QW-1]);
			fin_flags_s1 <= div_flags_s[QW-1];
		end
	end

	// round half up in integer mode, then saturate
	always_comb begin
		if (fin_flags_s1.round_int) begin
			rounded = (SW'(fin_sum_s1) + HALF) >> FRAC_BITS;
			maxv    = MAX_INT;
		end else begin
			rounded = SW'(fin_sum_s1);
			maxv    = MAX_Q;
		end
		sat = (fin_flags_s1.num_pos && fin_flags_s1.zero_gain) || (rounded > maxv);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fin_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_corr_q  <= sat ? maxv[W-1:0] : rounded[W-1:0];
			out_sat_q   <= sat;
			out_zero_q  <= fin_flags_s1.zero_gain;
			out_round_q <= fin_flags_s1.round_int;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.corrected       = out_corr_q;
	assign out_ch.saturated       = out_sat_q;
	assign out_ch.zero_gain_error = out_zero_q;

	// zero gain with positive numerator always ends saturated
	`FFPC_ASSERT_NEXT(a_zero_gain_sat, clk, arst_n, advance && fin_valid_s1 && fin_flags_s1.zero_gain && fin_flags_s1.num_pos, out_valid_q && out_sat_q)
	// a stalled pipe keeps its occupancy
	`FFPC_ASSERT_NEXT(a_stall_holds, clk, arst_n, !advance, $stable(div_valid_s) && $stable(fin_valid_s1))
	// integer results stay within the pixel range
	`FFPC_ASSERT_HOLDS(a_int_range, clk, arst_n, out_valid_q && out_round_q, out_corr_q <= MAX_INT[W-1:0])
endmodule

// ----- src/flat_field_pixel_correct_core.sv -----
// Flat field correction core: one voxel per cycle sustained throughput while
// the output is ready. Results pass through the divider pipeline, which forms
// one quotient bit per stage, then the offset add stage and the output register.
// A four-entry queue parts the front end from the divider, so input accepts go on
// while a finished result waits at the output register, until the queue is full.
// Reset (asynchronous, active low) empties queue and pipe and loads register defaults.
module flat_field_pixel_correct_core #(
	parameter int PIXEL_BITS     = 16,
	parameter int FRAC_BITS      = 4,
	parameter int GAIN_FRAC_BITS = 12,
	parameter int QUEUE_DEPTH    = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  ffpc_pkg::cfg_idx_t              cfg_index,
	input  logic [PIXEL_BITS+FRAC_BITS-1:0] cfg_data,
	ffpc_in_if.sink                         in_ch,
	ffpc_out_if.source                      out_ch
);
	localparam int W  = PIXEL_BITS + FRAC_BITS;
	localparam int GW = ffpc_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS;
	localparam int FW = $bits(ffpc_pkg::ffpc_flags_t);
	localparam int IW = FW + W + GW + W;

	logic                  offset_select_q;
	logic [W-1:0]          const_offset_q;
	logic                  round_int_q;

	logic                  push_valid;
	logic                  push_ready;
	logic [W-1:0]          f_num;
	logic [GW-1:0]         f_gain;
	logic [W-1:0]          f_addend;
	ffpc_pkg::ffpc_flags_t f_flags;

	logic                  pop_valid;
	logic                  pop_ready;
	logic [IW-1:0]         pop_data;
	logic [W-1:0]          b_num;
	logic [GW-1:0]         b_gain;
	logic [W-1:0]          b_addend;
	ffpc_pkg::ffpc_flags_t b_flags;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_select_q <= 1'b0;
			const_offset_q  <= '0;
			round_int_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				ffpc_pkg::REG_OFFSET_SELECT:    offset_select_q <= cfg_data[0];
				ffpc_pkg::REG_CONST_OFFSET:     const_offset_q  <= cfg_data;
				ffpc_pkg::REG_ROUND_TO_INTEGER: round_int_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ffpc_front #(
		.PIXEL_BITS     (PIXEL_BITS),
		.FRAC_BITS      (FRAC_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_front (
		.in_ch         (in_ch),
		.offset_select (offset_select_q),
		.const_offset  (const_offset_q),
		.round_int     (round_int_q),
		.push_ready    (push_ready),
		.push_valid    (push_valid),
		.num           (f_num),
		.gain          (f_gain),
		.addend        (f_addend),
		.flags         (f_flags)
	);

	ffpc_fifo #(
		.WIDTH (IW),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  ({f_flags, f_num, f_gain, f_addend}),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// unpack the queued item
	assign {b_flags, b_num, b_gain, b_addend} = pop_data;

	ffpc_back #(
		.PIXEL_BITS     (PIXEL_BITS),
		.FRAC_BITS      (FRAC_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.num       (b_num),
		.gain      (b_gain),
		.addend    (b_addend),
		.flags     (b_flags),
		.out_ch    (out_ch)
	);
endmodule

// ----- dv/flat_field_pixel_correct_core_checker.sv -----
// checker for the flat field correction core: predicts each corrected voxel and compares
`timescale 1ns / 100ps

module flat_field_pixel_correct_core_checker #(
	parameter int PIXEL_BITS     = 16,
	parameter int FRAC_BITS      = 4,
	parameter int GAIN_FRAC_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  ffpc_pkg::cfg_idx_t              cfg_index,
	input  logic [PIXEL_BITS+FRAC_BITS-1:0] cfg_data,
	ffpc_in_if                              in_ch,
	ffpc_out_if                             out_ch,
	output int                              errors,
	output int                              outstanding,
	output int                              checked,
	output int                              saturations
);
	localparam int WIDE   = PIXEL_BITS + FRAC_BITS;
	localparam int GAIN_W = ffpc_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS;

	typedef struct packed {
		logic [WIDE-1:0] corrected;
		logic            saturated;
		logic            zero_gain_error;
	} voxel_out_t;

	// shadow copy of the block's registers
	logic            add_const = 1'b0;
	logic [WIDE-1:0] offset_q  = '0;
	logic            round_int = 1'b1;

	voxel_out_t expected_voxels[$];
	int         err_n = 0;
	int         chk_n = 0;
	int         sat_n = 0;

	// (raw - background) / gain, clamped at zero, plus offset, then rounded and saturated
	function automatic voxel_out_t correct_voxel(input logic [PIXEL_BITS-1:0] raw,
		input logic [WIDE-1:0] bg, input logic [GAIN_W-1:0] gain);
		voxel_out_t  res;
		logic [63:0] scaled;
		logic [63:0] numer;
		logic [63:0] quot;
		logic [63:0] total;
		logic [63:0] value;
		logic [63:0] limit;
		logic        blowup;
		scaled = 64'(raw) << FRAC_BITS;
		quot   = '0;
		blowup = 1'b0;
		if (scaled > 64'(bg)) begin
			numer = scaled - 64'(bg);
			if (gain == '0)
				blowup = 1'b1;
			else
				quot = (numer << GAIN_FRAC_BITS) / 64'(gain);
		end
		total = quot + (add_const ? 64'(offset_q) : 64'(bg));
		if (round_int) begin
			limit = (64'd1 << PIXEL_BITS) - 1;
			if (FRAC_BITS > 0)
				value = (total + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			else
				value = total;
		end else begin
			limit = (64'd1 << WIDE) - 1;
			value = total;
		end
		res.saturated = 1'b0;
		if (blowup || value > limit) begin
			value         = limit;
			res.saturated = 1'b1;
		end
		res.corrected       = value[WIDE-1:0];
		res.zero_gain_error = (gain == '0);
		return res;
	endfunction

	always @(posedge clk) begin
		voxel_out_t want;
		voxel_out_t got;
		if (!arst_n) begin
			add_const = 1'b0;
			offset_q  = '0;
			round_int = 1'b1;
			expected_voxels.delete();
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					ffpc_pkg::REG_OFFSET_SELECT:    add_const = cfg_data[0];
					ffpc_pkg::REG_CONST_OFFSET:     offset_q  = cfg_data;
					ffpc_pkg::REG_ROUND_TO_INTEGER: round_int = cfg_data[0];
					default: ;
				endcase
			end
			// result item leaving the block
			if (out_ch.valid && out_ch.ready) begin
				got.corrected       = out_ch.corrected;
				got.saturated       = out_ch.saturated;
				got.zero_gain_error = out_ch.zero_gain_error;
				if (expected_voxels.size() == 0) begin
					err_n++;
					$display("%0t: unexpected result: corrected=%h sat=%b zge=%b", $time,
						got.corrected, got.saturated, got.zero_gain_error);
				end else begin
					want = expected_voxels.pop_front();
					chk_n++;
					if (got.saturated)
						sat_n++;
					if (got.corrected !== want.corrected) begin
						err_n++;
						$display("%0t: corrected mismatch: expected %h, actual %h", $time,
							want.corrected, got.corrected);
					end
					if (got.saturated !== want.saturated) begin
						err_n++;
						$display("%0t: saturated mismatch: expected %b, actual %b", $time,
							want.saturated, got.saturated);
					end
					if (got.zero_gain_error !== want.zero_gain_error) begin
						err_n++;
						$display("%0t: zero_gain_error mismatch: expected %b, actual %b", $time,
							want.zero_gain_error, got.zero_gain_error);
					end
				end
			end
			// voxel item entering the block
			if (in_ch.valid && in_ch.ready)
				expected_voxels.push_back(correct_voxel(in_ch.raw_pixel, in_ch.background,
					in_ch.flat_gain));
		end
		errors      <= err_n;
		checked     <= chk_n;
		saturations <= sat_n;
		outstanding <= expected_voxels.size();
	end

endmodule

// ----- dv/flat_field_pixel_correct_core_tb.sv -----
// top of the flat field correction testbench: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module flat_field_pixel_correct_core_tb;
	localparam int PIXEL_BITS     = 16;
	localparam int FRAC_BITS      = 4;
	localparam int GAIN_FRAC_BITS = 12;
	localparam int WIDE           = PIXEL_BITS + FRAC_BITS;
	localparam int GAIN_W         = ffpc_pkg::GAIN_INT_BITS + GAIN_FRAC_BITS;
	localparam int DRAIN_CYCLES   = 48;
	localparam int CYCLE_LIMIT    = 1000000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	ffpc_pkg::cfg_idx_t cfg_index;
	logic [WIDE-1:0]    cfg_data;

	int errors;
	int outstanding;
	int checked;
	int saturations;
	int cycle_count  = 0;
	int voxels_sent  = 0;
	int settings_run = 0;
	int steady_items = 0;
	int unsigned stall_left  = 0;
	int unsigned steady_left = 0;

	ffpc_in_if #(.PIX_W(PIXEL_BITS), .BG_W(WIDE), .GAIN_W(GAIN_W)) in_ch();
	ffpc_out_if #(.OUT_W(WIDE)) out_ch();

	flat_field_pixel_correct_core #(
		.PIXEL_BITS     (PIXEL_BITS),
		.FRAC_BITS      (FRAC_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	flat_field_pixel_correct_core_checker #(
		.PIXEL_BITS     (PIXEL_BITS),
		.FRAC_BITS      (FRAC_BITS),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.saturations (saturations)
	);

	always #4 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// zero, full scale, near either end or anywhere
	function automatic logic [WIDE-1:0] edgy(input int unsigned maxv);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return WIDE'(maxv);
			2: return WIDE'($urandom_range(0, 15));
			3: return WIDE'(maxv - $urandom_range(0, 15));
			default: return WIDE'($urandom_range(0, maxv));
		endcase
	endfunction

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycle_count, outstanding);
			$display("Some tests failed");
			$finish;
		end
	end

	// result backpressure with occasional steady stretches
	always @(posedge clk) begin
		int unsigned g;
		if (steady_left > 0) begin
			steady_left  <= steady_left - 1;
			out_ch.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			out_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 299) == 0) begin
			steady_left  <= $urandom_range(50, 200);
			out_ch.ready <= 1'b1;
		end else begin
			g = pick_gap();
			out_ch.ready <= (g == 0);
			stall_left   <= (g > 0) ? g - 1 : 0;
		end
	end

	// offer one voxel after a random gap and hold it until taken
	task automatic push_voxel(input logic [PIXEL_BITS-1:0] raw, input logic [WIDE-1:0] bg,
		input logic [GAIN_W-1:0] gain);
		int unsigned gap;
		if (steady_items > 0) begin
			gap = 0;
			steady_items--;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 59) == 0)
				steady_items = $urandom_range(30, 100);
		end
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.raw_pixel  <= raw;
		in_ch.background <= bg;
		in_ch.flat_gain  <= gain;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		voxels_sent++;
	endtask

	// random voxel: plain noise, camera-like frames, or corner values
	task automatic random_voxel();
		logic [PIXEL_BITS-1:0] raw;
		logic [WIDE-1:0]       bg;
		logic [WIDE-1:0]       scaled;
		logic [GAIN_W-1:0]     gain;
		int unsigned           r;
		int unsigned           d;
		r = $urandom_range(0, 99);
		if (r < 40) begin
			raw  = PIXEL_BITS'($urandom);
			bg   = WIDE'($urandom);
			gain = GAIN_W'($urandom);
		end else if (r < 75) begin
			raw    = PIXEL_BITS'($urandom);
			scaled = {raw, {FRAC_BITS{1'b0}}};
			d      = $urandom_range(0, 8192);
			if ($urandom_range(0, 4) == 0)
				bg = scaled + WIDE'($urandom_range(0, 255));
			else if (32'(scaled) > d)
				bg = scaled - WIDE'(d);
			else
				bg = WIDE'($urandom_range(0, 15));
			gain = GAIN_W'($urandom_range(16'h0800, 16'h2000));
		end else begin
			raw  = PIXEL_BITS'(edgy((1 << PIXEL_BITS) - 1));
			bg   = edgy((1 << WIDE) - 1);
			gain = ($urandom_range(0, 3) == 0) ? '0 : GAIN_W'(edgy((1 << GAIN_W) - 1));
		end
		push_voxel(raw, bg, gain);
	endtask

	// wait until every voxel sent has come back
	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_reg(input ffpc_pkg::cfg_idx_t idx, input logic [WIDE-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// program all registers while idle, then stream random voxels
	task automatic run_setting(input logic sel, input logic [WIDE-1:0] offs,
		input logic rint, input int count);
		wait_idle();
		write_reg(ffpc_pkg::REG_OFFSET_SELECT, WIDE'(sel));
		write_reg(ffpc_pkg::REG_CONST_OFFSET, offs);
		write_reg(ffpc_pkg::REG_ROUND_TO_INTEGER, WIDE'(rint));
		cfg_we <= 1'b0;
		settings_run++;
		repeat (count) random_voxel();
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = ffpc_pkg::REG_OFFSET_SELECT;
		cfg_data         = '0;
		in_ch.valid      = 1'b0;
		in_ch.raw_pixel  = '0;
		in_ch.background = '0;
		in_ch.flat_gain  = '0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed voxels at reset register values
		push_voxel(16'h0000, 20'h00000, 16'h0000);   // zero gain, zero numerator
		push_voxel(16'hFFFF, 20'h00000, 16'h0000);   // zero gain, positive numerator
		push_voxel(16'h0064, 20'h00640, 16'h0000);   // zero gain, raw equals background
		push_voxel(16'h000A, 20'hFFFFF, 16'h0000);   // zero gain, negative numerator
		push_voxel(16'hFFFF, 20'h00000, 16'h0001);   // huge quotient
		push_voxel(16'hFFFF, 20'h00000, 16'hFFFF);
		push_voxel(16'hFFFF, 20'hFFFFF, 16'h1000);   // clamp, rounding overflows
		push_voxel(16'h0000, 20'hFFFFF, 16'hFFFF);
		push_voxel(16'h0001, 20'h00000, 16'h1000);   // unity gain
		push_voxel(16'h1234, 20'h00008, 16'h1000);
		push_voxel(16'h0005, 20'h00047, 16'h1000);
		push_voxel(16'h0000, 20'h00017, 16'h1000);   // fraction just under half
		push_voxel(16'h0000, 20'h00018, 16'h1000);   // fraction exactly half
		push_voxel(16'h8000, 20'h00000, 16'h8000);
		push_voxel(16'hFFFF, 20'hFFFFF, 16'hFFFF);
		push_voxel(16'hAAAA, 20'h55555, 16'h5555);
		push_voxel(16'h5555, 20'hAAAAA, 16'hAAAA);
		push_voxel(16'h0FFF, 20'h0FFF0, 16'h1000);   // numerator exactly zero
		push_voxel(16'h1000, 20'h0FFFF, 16'hFFFF);   // smallest positive numerator

		run_setting(1'b0, 20'h00000, 1'b1, 200);
		run_setting(1'b1, 20'h00000, 1'b0, 200);
		run_setting(1'b1, 20'hFFFFF, 1'b1, 150);
		run_setting(1'b1, 20'hFFFFF, 1'b0, 150);
		run_setting(1'b0, 20'hFFFFF, 1'b0, 200);
		run_setting(1'b1, WIDE'($urandom), 1'b1, 200);
		run_setting(1'b1, WIDE'($urandom), 1'b0, 150);
		run_setting(1'($urandom), WIDE'($urandom), 1'($urandom), 150);

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d voxels under %0d register settings plus reset values",
			voxels_sent, settings_run);
		$display("checked %0d results, %0d of them saturated", checked, saturations);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
